// ===== rtl/core/dchpr_pkg.sv =====
package dchpr_pkg;

    // Field widths of the stream payload
    localparam int CMD_W  = 2;
    localparam int COL_W  = 1;
    localparam int ROW_W  = 9;
    localparam int HITS_W = 11;

    localparam int IN_DATA_W  = 16;   // command + column + row, padded to bytes
    localparam int OUT_DATA_W = 24;   // hit_found + column + row + count, padded

    // Geometry defaults
    localparam int ROWS_DEF   = 512;
    localparam int NUM_COLS   = 2;
    localparam int MAP_WORD_W = 32;                    // rows held per map word
    localparam int MAP_BIT_W  = $clog2(MAP_WORD_W);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSPECT = 2'd2;

    // Request from the command stage into the hit map
    typedef struct packed {
        logic             set_en;    // mark the addressed pixel this cycle
        logic             read_en;   // clear the lowest hit this cycle
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } map_req_t;

    // Lookup and priority search results from the hit map
    typedef struct packed {
        logic             pix_hit;   // addressed pixel in range and hit
        logic             pix_free;  // addressed pixel in range and not hit
        logic             rd_any;    // at least one hit stored
        logic [COL_W-1:0] rd_col;    // lowest hit, column-major
        logic [ROW_W-1:0] rd_row;
    } map_stat_t;

endpackage

// ===== rtl/core/dchpr_map.sv =====
module dchpr_map #(
    parameter int ROWS = dchpr_pkg::ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dchpr_pkg::map_req_t  req,
    output dchpr_pkg::map_stat_t stat
);
    import dchpr_pkg::*;

    // Map words per column; at least two so the word index has a bit
    localparam int NW_RAW = (ROWS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int NW     = (NW_RAW < 2) ? 2 : NW_RAW;
    localparam int WIDX_W = $clog2(NW);
    localparam int RX_W   = WIDX_W + MAP_BIT_W;

    logic [MAP_WORD_W-1:0] map_reg [NUM_COLS][NW];

    // Pixel addressed by set / inspect
    logic [RX_W-1:0]       row_x;
    logic [WIDX_W-1:0]     widx_p;
    logic [MAP_BIT_W-1:0]  bit_p;
    logic                  in_range;
    logic [MAP_WORD_W-1:0] word_p;
    logic                  pix_bit;

    assign row_x    = RX_W'(req.row);
    assign widx_p   = row_x[RX_W-1:MAP_BIT_W];
    assign bit_p    = row_x[MAP_BIT_W-1:0];
    assign in_range = 32'(req.row) < 32'(ROWS);
    assign word_p   = map_reg[req.col][widx_p];
    assign pix_bit  = word_p[bit_p];

    // Per-word occupancy summary for both columns
    logic [NW-1:0] sum0;
    logic [NW-1:0] sum1;

    always_comb
    begin
        for (int w = 0; w < NW; w++)
        begin
            sum0[w] = |map_reg[0][w];
            sum1[w] = |map_reg[1][w];
        end
    end

    // Priority search: column 0 first, then lowest word, then lowest bit
    logic                  rd_any;
    logic [COL_W-1:0]      rd_col;
    logic [NW-1:0]         sum_sel;
    logic [NW-1:0]         sum_low;
    logic [WIDX_W-1:0]     widx_r;
    logic [MAP_WORD_W-1:0] word_r;
    logic [MAP_WORD_W-1:0] word_low;
    logic [MAP_BIT_W-1:0]  bit_r;

    assign rd_any   = (|sum0) | (|sum1);
    assign rd_col   = COL_W'(~|sum0);
    assign sum_sel  = (|sum0) ? sum0 : sum1;
    assign sum_low  = sum_sel & (~sum_sel + NW'(1));
    assign word_r   = map_reg[rd_col][widx_r];
    assign word_low = word_r & (~word_r + MAP_WORD_W'(1));

    // One-hot to index encoders
    always_comb
    begin
        widx_r = '0;
        for (int j = 0; j < NW; j++)
        begin
            if (sum_low[j])
                widx_r = widx_r | WIDX_W'(j);
        end
    end

    always_comb
    begin
        bit_r = '0;
        for (int j = 0; j < MAP_WORD_W; j++)
        begin
            if (word_low[j])
                bit_r = bit_r | MAP_BIT_W'(j);
        end
    end

    assign stat.pix_hit  = in_range & pix_bit;
    assign stat.pix_free = in_range & ~pix_bit;
    assign stat.rd_any   = rd_any;
    assign stat.rd_col   = rd_col;
    assign stat.rd_row   = ROW_W'({widx_r, bit_r});

    // Map update: set marks one bit, read clears the lowest bit of the found word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                for (int w = 0; w < NW; w++)
                    map_reg[c][w] <= '0;
            end
        end
        else if (req.set_en && in_range && !pix_bit)
        begin
            map_reg[req.col][widx_p][bit_p] <= 1'b1;
        end
        else if (req.read_en && rd_any)
        begin
            map_reg[rd_col][widx_r] <= word_r & (word_r - MAP_WORD_W'(1));
        end
    end

endmodule

// ===== rtl/core/double_column_hit_priority_readout_unit.sv =====
// Hit map for one double column (two columns by ROWS rows) with priority
// readout. Each command on the input stream yields exactly one result: set
// marks a pixel, read returns and clears the lowest stored hit (column 0
// first, then rising row), inspect reports one pixel without changing it; all
// results carry the number of hits left. The unit takes one command per clock
// while the output is not stalled; a command waits in the input register, then
// the map lookup and priority search run in a single pass into the output
// register. The map is cleared by reset and ready at once.
module double_column_hit_priority_readout_unit #(
    parameter int ROWS = dchpr_pkg::ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] command, [2] column, [11:3] row, [15:12] zero
    input  logic [dchpr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] hit_found, [1] out_column, [10:2] out_row, [21:11] hits_remaining,
    // [23:22] zero
    output logic [dchpr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import dchpr_pkg::*;

    localparam int CNT_W = $clog2(2 * ROWS + 1);
    localparam int OUT_USED_W = 1 + COL_W + ROW_W + HITS_W;

    // Input register
    logic             in_valid_reg;
    logic [CMD_W-1:0] in_cmd_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_USED_W-1:0] out_data_reg;
    logic [OUT_USED_W-1:0] out_data_next;

    // Hit counter
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic      advance;
    logic      in_xfer;
    map_req_t  mreq;
    map_stat_t mstat;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_xfer)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_cmd_reg <= s_axis_tdata[CMD_W-1:0];
            in_col_reg <= s_axis_tdata[CMD_W +: COL_W];
            in_row_reg <= s_axis_tdata[CMD_W + COL_W +: ROW_W];
        end
    end

    // Map request, updates only when the command moves on
    assign mreq.set_en  = advance && (in_cmd_reg == CMD_SET);
    assign mreq.read_en = advance && (in_cmd_reg == CMD_READ);
    assign mreq.col     = in_col_reg;
    assign mreq.row     = in_row_reg;

    dchpr_map #(
        .ROWS (ROWS)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .stat  (mstat)
    );

    // Hit count after this command
    assign count_next = count_reg
                      + CNT_W'(mreq.set_en && mstat.pix_free)
                      - CNT_W'(mreq.read_en && mstat.rd_any);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (advance)
            count_reg <= count_next;
    end

    // Result formatting
    always_comb
    begin
        unique case (in_cmd_reg)
            CMD_READ:
            begin
                out_data_next = {HITS_W'(count_next),
                                 mstat.rd_any ? mstat.rd_row : ROW_W'(0),
                                 mstat.rd_any ? mstat.rd_col : COL_W'(0),
                                 mstat.rd_any};
            end
            CMD_INSPECT:
            begin
                out_data_next = {HITS_W'(count_next), in_row_reg, in_col_reg,
                                 mstat.pix_hit};
            end
            default:
            begin
                // set and the unused code: echo, nothing found
                out_data_next = {HITS_W'(count_next), in_row_reg, in_col_reg, 1'b0};
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_data_reg);

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 2 * ROWS)
        else $error("hit count above map size");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (mreq.read_en && !mstat.rd_any) |-> (count_reg == '0))
        else $error("read found no hit while count is nonzero");

    a_read_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (mreq.read_en && mstat.rd_any) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("read of a hit did not lower the count");

    a_inspect_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_cmd_reg == CMD_INSPECT) |=> $stable(count_reg))
        else $error("inspect changed the hit count");

endmodule
